// ===== design/x86_memory_operand_address_check_unit_defines.svh =====
// Assertion macros used by the checker file of the address check unit.
`ifndef X86_MEMORY_OPERAND_ADDRESS_CHECK_UNIT_DEFINES_SVH
`define X86_MEMORY_OPERAND_ADDRESS_CHECK_UNIT_DEFINES_SVH

// A property that is only meaningful once reset has been released.
`define XMOAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// A property that must also hold while reset is asserted.
`define XMOAC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/xmoac_pkg.sv =====
package xmoac_pkg;

   // Fault reported with each result.
   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_UD   = 2'd1,
      FAULT_GP   = 2'd2,
      FAULT_SS   = 2'd3
   } fault_kind_type;

   // Fields of the packed instruction-information word.
   localparam int unsigned INFO_SCALE_LSB  = 0;
   localparam int unsigned INFO_ASIZE_LSB  = 7;
   localparam int unsigned INFO_REG_OP_BIT = 10;
   localparam int unsigned INFO_SEG_LSB    = 15;
   localparam int unsigned INFO_IDX_INV    = 22;
   localparam int unsigned INFO_BASE_INV   = 27;

   localparam logic [2:0] ASIZE_32BIT = 3'd1;
   localparam logic [2:0] SEG_NUM_SS  = 3'd2;

   // Segment type bits that matter for the access check.
   localparam logic [3:0] TYPE_CHECK_MASK = 4'ha;
   localparam logic [3:0] TYPE_CODE_BIT   = 4'h8;

   localparam logic [64:0] LIMIT_MARGIN = 65'd8;

   // After the first stage: partial offset and decoded controls.
   typedef struct packed {
      logic [63:0] sum;
      logic [63:0] idx_term;
      logic [63:0] seg_base;
      logic [31:0] seg_limit;
      logic        is_write;
      logic [3:0]  seg_type;
      logic        seg_unusable;
      logic        long_mode;
      logic        prot_mode;
      logic        asize_32;
      logic        reg_op;
      logic        seg_is_ss;
   } partial_item_type;

   // After the second stage: full offset and type check.
   typedef struct packed {
      logic [63:0] off;
      logic [63:0] seg_base;
      logic [31:0] seg_limit;
      logic        bad_type;
      logic        seg_unusable;
      logic        long_mode;
      logic        prot_mode;
      logic        asize_32;
      logic        reg_op;
      logic        seg_is_ss;
   } offset_item_type;

   // After the third stage: linear address and limit check.
   typedef struct packed {
      logic [63:0] addr;
      logic        over_limit;
      logic        bad_type;
      logic        seg_unusable;
      logic        long_mode;
      logic        prot_mode;
      logic        reg_op;
      logic        seg_is_ss;
   } linear_item_type;

endpackage

// ===== design/xmoac_offset.sv =====
module xmoac_offset (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  logic [63:0]                displacement,
   input  logic [31:0]                instr_info,
   input  logic                       is_write,
   input  logic [63:0]                base_value,
   input  logic [63:0]                index_value,
   input  logic [63:0]                seg_base,
   input  logic [31:0]                seg_limit,
   input  logic [3:0]                 seg_type,
   input  logic                       seg_unusable,
   input  logic                       long_mode,
   input  logic                       prot_mode,
   output logic                       out_valid,
   input  logic                       out_stall,
   output xmoac_pkg::offset_item_type out_item
);

   logic                        valid_a_ff;
   xmoac_pkg::partial_item_type item_a_ff;
   xmoac_pkg::partial_item_type item_a_in;
   logic                        ready_a;
   logic                        valid_b_ff;
   xmoac_pkg::offset_item_type  item_b_ff;
   xmoac_pkg::offset_item_type  item_b_in;
   logic                        ready_b;
   logic                        base_ok;
   logic                        idx_ok;
   logic [1:0]                  scale;
   logic                        bad_type;

   // A stage takes a new request when it is empty or its content moves on.
   assign ready_b  = !valid_b_ff || !out_stall;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_stall = !ready_a;

   assign base_ok = !instr_info[xmoac_pkg::INFO_BASE_INV];
   assign idx_ok  = !instr_info[xmoac_pkg::INFO_IDX_INV];
   assign scale   = instr_info[xmoac_pkg::INFO_SCALE_LSB +: 2];

   always_comb begin
      item_a_in.sum          = displacement + (base_ok ? base_value : 64'd0);
      item_a_in.idx_term     = idx_ok ? (index_value << scale) : 64'd0;
      item_a_in.seg_base     = seg_base;
      item_a_in.seg_limit    = seg_limit;
      item_a_in.is_write     = is_write;
      item_a_in.seg_type     = seg_type;
      item_a_in.seg_unusable = seg_unusable;
      item_a_in.long_mode    = long_mode;
      item_a_in.prot_mode    = prot_mode;
      item_a_in.asize_32     = instr_info[xmoac_pkg::INFO_ASIZE_LSB +: 3]
                               == xmoac_pkg::ASIZE_32BIT;
      item_a_in.reg_op       = instr_info[xmoac_pkg::INFO_REG_OP_BIT];
      item_a_in.seg_is_ss    = instr_info[xmoac_pkg::INFO_SEG_LSB +: 3]
                               == xmoac_pkg::SEG_NUM_SS;
   end

   // Writes need a writable data segment; reads fail only on execute-only code.
   always_comb begin
      if (item_a_ff.is_write) begin
         bad_type = ((item_a_ff.seg_type & xmoac_pkg::TYPE_CHECK_MASK) == 4'h0)
                    || ((item_a_ff.seg_type & xmoac_pkg::TYPE_CODE_BIT) != 4'h0);
      end else begin
         bad_type = (item_a_ff.seg_type & xmoac_pkg::TYPE_CHECK_MASK)
                    == xmoac_pkg::TYPE_CODE_BIT;
      end
   end

   always_comb begin
      item_b_in.off          = item_a_ff.sum + item_a_ff.idx_term;
      item_b_in.seg_base     = item_a_ff.seg_base;
      item_b_in.seg_limit    = item_a_ff.seg_limit;
      item_b_in.bad_type     = bad_type;
      item_b_in.seg_unusable = item_a_ff.seg_unusable;
      item_b_in.long_mode    = item_a_ff.long_mode;
      item_b_in.prot_mode    = item_a_ff.prot_mode;
      item_b_in.asize_32     = item_a_ff.asize_32;
      item_b_in.reg_op       = item_a_ff.reg_op;
      item_b_in.seg_is_ss    = item_a_ff.seg_is_ss;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         item_a_ff <= item_a_in;
      end
      if (ready_b && valid_a_ff) begin
         item_b_ff <= item_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_item  = item_b_ff;

endmodule

// ===== design/xmoac_check.sv =====
module xmoac_check #(
   parameter int unsigned VirtAddrBits = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  xmoac_pkg::offset_item_type in_item,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic [63:0]                address,
   output logic [1:0]                 fault_kind
);

   // Bits that must all match the sign bit of the virtual address.
   localparam logic [63:0] TopMask = ~((64'd1 << (VirtAddrBits - 1)) - 64'd1);

   logic                       valid_c_ff;
   xmoac_pkg::linear_item_type item_c_ff;
   xmoac_pkg::linear_item_type item_c_in;
   logic                       ready_c;
   logic                       valid_d_ff;
   logic [63:0]                address_ff;
   logic [63:0]                address_in;
   xmoac_pkg::fault_kind_type  fault_ff;
   xmoac_pkg::fault_kind_type  fault_in;
   logic                       ready_d;
   logic [63:0]                lin_sum;
   logic [63:0]                top_bits;
   logic                       canonical;
   xmoac_pkg::fault_kind_type  seg_fault;

   assign ready_d  = !valid_d_ff || !out_stall;
   assign ready_c  = !valid_c_ff || ready_d;
   assign in_stall = !ready_c;

   assign lin_sum = in_item.seg_base + in_item.off;

   // The limit compare is made at 65 bits so that offset plus eight never wraps.
   always_comb begin
      item_c_in.addr         = in_item.asize_32 ? {32'd0, lin_sum[31:0]} : lin_sum;
      item_c_in.over_limit   = ({1'b0, in_item.off} + xmoac_pkg::LIMIT_MARGIN)
                               > {33'd0, in_item.seg_limit};
      item_c_in.bad_type     = in_item.bad_type;
      item_c_in.seg_unusable = in_item.seg_unusable;
      item_c_in.long_mode    = in_item.long_mode;
      item_c_in.prot_mode    = in_item.prot_mode;
      item_c_in.reg_op       = in_item.reg_op;
      item_c_in.seg_is_ss    = in_item.seg_is_ss;
   end

   assign top_bits  = item_c_ff.addr & TopMask;
   assign canonical = (top_bits == 64'd0) || (top_bits == TopMask);
   assign seg_fault = item_c_ff.seg_is_ss ? xmoac_pkg::FAULT_SS : xmoac_pkg::FAULT_GP;

   // Long mode takes precedence over protected mode.
   always_comb begin
      priority if (item_c_ff.reg_op) begin
         fault_in = xmoac_pkg::FAULT_UD;
      end else if (item_c_ff.long_mode) begin
         fault_in = canonical ? xmoac_pkg::FAULT_NONE : seg_fault;
      end else if (item_c_ff.prot_mode && item_c_ff.bad_type) begin
         fault_in = xmoac_pkg::FAULT_GP;
      end else if (item_c_ff.prot_mode
                   && (item_c_ff.seg_unusable || item_c_ff.over_limit)) begin
         fault_in = seg_fault;
      end else begin
         fault_in = xmoac_pkg::FAULT_NONE;
      end
   end

   assign address_in = (fault_in == xmoac_pkg::FAULT_NONE) ? item_c_ff.addr : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         if (ready_c) begin
            valid_c_ff <= in_valid;
         end
         if (ready_d) begin
            valid_d_ff <= valid_c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_c && in_valid) begin
         item_c_ff <= item_c_in;
      end
      if (ready_d && valid_c_ff) begin
         address_ff <= address_in;
         fault_ff   <= fault_in;
      end
   end

   assign out_valid  = valid_d_ff;
   assign address    = address_ff;
   assign fault_kind = fault_ff;

endmodule

// ===== design/x86_memory_operand_address_check_unit.sv =====
// Memory-operand effective address and segment check.
//
// Requests arrive on the req_ channel: the displacement, the packed
// instruction-information word, the write flag, the base and index register
// values, the selected segment's base, limit, type and unusable mark, and the
// processor mode. A request is taken at a rising edge where req_valid is high
// and req_stall is low. Each request yields exactly one result on the rsp_
// channel: the linear address and a fault kind, the address being zero when
// any fault is reported.
//
// The work runs through four register stages: base plus displacement and the
// scaled index, the full offset and segment type check, the linear address
// and limit compare, and finally the canonical check and fault selection into
// the output register, which drives rsp_. One request per cycle is accepted
// for as long as the receiver keeps rsp_stall low.
//
// When rsp_stall is high the result holds steady on the outputs and the stages
// behind it keep filling any empty slots; req_stall rises only once all four
// stages are occupied. Reset empties the pipeline and drops rsp_valid.
module x86_memory_operand_address_check_unit #(
   parameter int unsigned VIRT_ADDR_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_displacement,
   input  logic [31:0] req_instr_info,
   input  logic        req_is_write,
   input  logic [63:0] req_base_value,
   input  logic [63:0] req_index_value,
   input  logic [63:0] req_seg_base,
   input  logic [31:0] req_seg_limit,
   input  logic [3:0]  req_seg_type,
   input  logic        req_seg_unusable,
   input  logic        req_long_mode,
   input  logic        req_prot_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_address,
   output logic [1:0]  rsp_fault_kind
);

   // Link between the offset stages and the checking stages.
   logic                       mid_valid;
   logic                       mid_stall;
   xmoac_pkg::offset_item_type mid_item;

   // The first two stages build the offset and judge the segment type.
   xmoac_offset u_offset (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .displacement (req_displacement),
      .instr_info   (req_instr_info),
      .is_write     (req_is_write),
      .base_value   (req_base_value),
      .index_value  (req_index_value),
      .seg_base     (req_seg_base),
      .seg_limit    (req_seg_limit),
      .seg_type     (req_seg_type),
      .seg_unusable (req_seg_unusable),
      .long_mode    (req_long_mode),
      .prot_mode    (req_prot_mode),
      .out_valid    (mid_valid),
      .out_stall    (mid_stall),
      .out_item     (mid_item)
   );

   // The last two stages form the linear address and pick the fault; the
   // final stage is the output register seen on the rsp_ ports.
   xmoac_check #(
      .VirtAddrBits (VIRT_ADDR_BITS)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_stall   (mid_stall),
      .in_item    (mid_item),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .address    (rsp_address),
      .fault_kind (rsp_fault_kind)
   );

endmodule

// ===== design/xmoac_checker.sv =====
`include "x86_memory_operand_address_check_unit_defines.svh"

module xmoac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_address,
   input logic [1:0]  rsp_fault_kind
);

   // A held result must not change under the receiver's stall.
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_address)
                                 && $stable(rsp_fault_kind);
   endproperty

   // Any faulting result carries a zero address.
   property p_fault_zero_addr;
      rsp_valid && (rsp_fault_kind != xmoac_pkg::FAULT_NONE) |-> rsp_address == 64'd0;
   endproperty

   // With the output register empty the pipeline can always take a request.
   property p_no_stall_when_empty;
      !rsp_valid |-> !req_stall;
   endproperty

   // Reset empties the pipeline.
   property p_reset_empties;
      reset |=> !rsp_valid;
   endproperty

   `XMOAC_ASSERT(a_rsp_hold, p_rsp_hold, "result changed while stalled")
   `XMOAC_ASSERT(a_fault_zero_addr, p_fault_zero_addr, "faulting result with non-zero address")
   `XMOAC_ASSERT(a_no_stall_when_empty, p_no_stall_when_empty, "request stalled, output empty")
   `XMOAC_ASSERT_ALWAYS(a_reset_empties, p_reset_empties, "result offered after reset")

endmodule

bind x86_memory_operand_address_check_unit xmoac_checker u_xmoac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_address    (rsp_address),
   .rsp_fault_kind (rsp_fault_kind)
);
